[design/wlvb_pkg.sv]
// wlvb_pkg: shared types, codes and the microcode program of the voted byte store
// used by wlvb_seq, wlvb_dpath and the top level
package wlvb_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int MAX_SLOTS   = 256;
    localparam int MAX_COPIES  = 8;
    localparam int MIN_COPIES  = 2;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int COPY_W      = $clog2(MAX_COPIES);
    localparam int PC_W        = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COPIES      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MARK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_MARK  = 3'd4;

    localparam logic [1:0] FUNC_FRESH  = 2'd0;
    localparam logic [1:0] FUNC_RESUME = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_WRITE  = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] write_value;
        logic [7:0] start_slot;
    } t_item;

    typedef struct packed {
        logic [7:0] read_value;
        logic       fault;
        logic [7:0] slot_now;
    } t_result;

    typedef struct packed {
        logic [8:0] slot_count;
        logic [9:0] base_address;
        logic [3:0] copies_per_slot;
        logic [7:0] empty_marker;
        logic [7:0] error_marker;
    } t_cfg;

    typedef enum logic [3:0] {
        A_NOP,
        A_DIV_LD_START,
        A_DIV_LD_NEXT,
        A_DIV_STEP,
        A_SET_CUR,
        A_FILL,
        A_SEL_CUR,
        A_SCAN_INIT,
        A_RD,
        A_CAP,
        A_VOTE,
        A_READ_RES,
        A_SCAN_EVAL,
        A_SCAN_NEXT,
        A_SCAN_END,
        A_FIN
    } t_act;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_END,
        C_DIV_MORE,
        C_LIN_MORE,
        C_COPY_MORE,
        C_VOTE_MORE,
        C_RESUME,
        C_HIT,
        C_SLOT_MORE,
        C_NO_ADV
    } t_cond;

    // write path reuses a few actions with its own meaning
    localparam t_act A_WCOUNT   = A_SCAN_INIT;

    typedef struct packed {
        t_act             act;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        t_act act;
        logic accept;
        logic wr_path;
    } t_ctl;

    typedef struct packed {
        logic div_more;
        logic lin_more;
        logic copy_more;
        logic vote_more;
        logic resume;
        logic hit;
        logic slot_more;
        logic no_adv;
    } t_stat;

    localparam logic [PC_W-1:0] PC_FRESH  = 5'd0;
    localparam logic [PC_W-1:0] PC_FIN    = 5'd4;
    localparam logic [PC_W-1:0] PC_READ   = 5'd5;
    localparam logic [PC_W-1:0] PC_RESUME = 5'd6;
    localparam logic [PC_W-1:0] PC_VLOAD  = 5'd7;
    localparam logic [PC_W-1:0] PC_VOTE   = 5'd9;
    localparam logic [PC_W-1:0] PC_SEVAL  = 5'd12;
    localparam logic [PC_W-1:0] PC_SEND   = 5'd14;
    localparam logic [PC_W-1:0] PC_WRITE  = 5'd15;
    localparam logic [PC_W-1:0] PC_WEMPTY = 5'd17;
    localparam logic [PC_W-1:0] PC_WDIV   = 5'd19;
    localparam logic [PC_W-1:0] PC_WVAL   = 5'd21;

    function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] func);
        logic [PC_W-1:0] pc;
        case (func)
            FUNC_FRESH:  pc = PC_FRESH;
            FUNC_RESUME: pc = PC_RESUME;
            FUNC_READ:   pc = PC_READ;
            default:     pc = PC_WRITE;
        endcase
        return pc;
    endfunction

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            // init fresh: start modulo slot count, then fill the ring
            5'd0:    w = '{A_DIV_LD_START, C_NEXT,      '0};
            5'd1:    w = '{A_DIV_STEP,     C_DIV_MORE,  5'd1};
            5'd2:    w = '{A_SET_CUR,      C_NEXT,      '0};
            5'd3:    w = '{A_FILL,         C_LIN_MORE,  5'd3};
            5'd4:    w = '{A_FIN,          C_END,       '0};
            // read and resume share the vote
            5'd5:    w = '{A_SEL_CUR,      C_ALWAYS,    PC_VLOAD};
            5'd6:    w = '{A_SCAN_INIT,    C_NEXT,      '0};
            5'd7:    w = '{A_RD,           C_NEXT,      '0};
            5'd8:    w = '{A_CAP,          C_COPY_MORE, PC_VLOAD};
            5'd9:    w = '{A_VOTE,         C_VOTE_MORE, PC_VOTE};
            5'd10:   w = '{A_NOP,          C_RESUME,    PC_SEVAL};
            5'd11:   w = '{A_READ_RES,     C_ALWAYS,    PC_FIN};
            5'd12:   w = '{A_SCAN_EVAL,    C_HIT,       PC_SEND};
            5'd13:   w = '{A_SCAN_NEXT,    C_SLOT_MORE, PC_VLOAD};
            5'd14:   w = '{A_SCAN_END,     C_ALWAYS,    PC_FIN};
            // write
            5'd15:   w = '{A_WCOUNT,       C_NEXT,      '0};
            5'd16:   w = '{A_NOP,          C_NO_ADV,    PC_WVAL};
            5'd17:   w = '{A_FILL,         C_COPY_MORE, PC_WEMPTY};
            5'd18:   w = '{A_DIV_LD_NEXT,  C_NEXT,      '0};
            5'd19:   w = '{A_DIV_STEP,     C_DIV_MORE,  PC_WDIV};
            5'd20:   w = '{A_SET_CUR,      C_NEXT,      '0};
            5'd21:   w = '{A_RD,           C_COPY_MORE, PC_WVAL};
            5'd22:   w = '{A_NOP,          C_ALWAYS,    PC_FIN};
            default: w = '{A_FIN,          C_END,       '0};
        endcase
        return w;
    endfunction

endpackage

[design/wear_levelled_voted_byte_store_core.sv]
// wear_levelled_voted_byte_store_core: top level of the wear-levelled voted byte store
// depends on wlvb_pkg, wlvb_seq and wlvb_dpath
//
// One item is taken when start is high and busy is low; its result shows on o_result
// for exactly one cycle with o_valid high and cannot be held off. Every operation
// walks the single-port 1024-byte store byte by byte, so its length follows
// slot_count and copies_per_slot; a write that advances the ring also runs a
// nine-step remainder. The next item can be started in the cycle the result is shown.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// do so only while the block is idle, which the block itself does not enforce.
module wear_levelled_voted_byte_store_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  wlvb_pkg::t_item                        i_item,
    output logic                                   o_valid,
    output wlvb_pkg::t_result                      o_result,
    input  logic                                   i_cfg_we,
    input  logic [wlvb_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [wlvb_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import wlvb_pkg::*;

    t_cfg  r_cfg;
    t_ctl  ctl;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_count      <= 9'd16;
            r_cfg.base_address    <= 10'd0;
            r_cfg.copies_per_slot <= 4'd3;
            r_cfg.empty_marker    <= 8'd255;
            r_cfg.error_marker    <= 8'd254;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SLOT_COUNT: r_cfg.slot_count      <= i_cfg_data[8:0];
                REG_BASE_ADDR:  r_cfg.base_address    <= i_cfg_data[9:0];
                REG_COPIES:     r_cfg.copies_per_slot <= i_cfg_data[3:0];
                REG_EMPTY_MARK: r_cfg.empty_marker    <= i_cfg_data[7:0];
                REG_ERROR_MARK: r_cfg.error_marker    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    wlvb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    wlvb_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

[design/wlvb_seq.sv]
// wlvb_seq: step counter and microcode table that drive the datapath
// depends on wlvb_pkg
module wlvb_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_func,
    input  wlvb_pkg::t_stat      i_stat,
    output wlvb_pkg::t_ctl       o_ctl,
    output logic                 o_busy,
    output logic                 o_done
);
    import wlvb_pkg::*;

    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_run, n_run;
    logic            r_done, n_done;
    logic            r_wr, n_wr;
    t_uword          uw;
    logic            take;
    logic            accept;

    assign uw     = ucode(r_pc);
    assign accept = i_start && !r_run;

    always_comb begin
        case (uw.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_DIV_MORE:  take = i_stat.div_more;
            C_LIN_MORE:  take = i_stat.lin_more;
            C_COPY_MORE: take = i_stat.copy_more;
            C_VOTE_MORE: take = i_stat.vote_more;
            C_RESUME:    take = i_stat.resume;
            C_HIT:       take = i_stat.hit;
            C_SLOT_MORE: take = i_stat.slot_more;
            C_NO_ADV:    take = i_stat.no_adv;
            default:     take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_run  = r_run;
        n_done = 1'b0;
        n_wr   = r_wr;
        if (!r_run) begin
            if (accept) begin
                n_pc  = entry_pc(i_func);
                n_run = 1'b1;
                n_wr  = (i_func == FUNC_WRITE);
            end
        end else if (uw.cond == C_END) begin
            n_run  = 1'b0;
            n_done = 1'b1;
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_wr   <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_run  <= n_run;
            r_done <= n_done;
            r_wr   <= n_wr;
        end
    end

    assign o_ctl.act     = r_run ? uw.act : A_NOP;
    assign o_ctl.accept  = accept;
    assign o_ctl.wr_path = r_wr;
    assign o_busy        = r_run;
    assign o_done        = r_done;

endmodule

[design/wlvb_dpath.sv]
// wlvb_dpath: byte store, copy buffer, vote, remainder unit and slot registers
// depends on wlvb_pkg, driven by wlvb_seq
module wlvb_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wlvb_pkg::t_ctl       i_ctl,
    input  wlvb_pkg::t_item      i_item,
    input  wlvb_pkg::t_cfg       i_cfg,
    output wlvb_pkg::t_stat      o_stat,
    output wlvb_pkg::t_result    o_result
);
    import wlvb_pkg::*;

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_rdata;
    logic [7:0]        r_buf [MAX_COPIES];

    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [8:0]        r_wc, n_wc;
    logic [SLOT_W-1:0] r_slot;
    logic [COPY_W-1:0] r_copy;
    logic [10:0]       r_lin;
    logic [8:0]        r_dvd;
    logic [7:0]        r_rem;
    logic [3:0]        r_dcnt;
    logic              r_vok;
    logic [7:0]        r_vval;
    logic              r_resume;
    logic              r_found;
    logic              r_adv;
    logic [7:0]        r_rv;
    logic              r_fault;
    logic [7:0]        r_wv;
    logic [7:0]        r_start;
    t_result           r_res;

    logic [8:0]        eff_n;
    logic [3:0]        eff_c;
    logic [12:0]       total;
    logic [11:0]       prod;
    logic [11:0]       slot_sum;
    logic [ADDR_W-1:0] addr;
    logic              mem_we;
    logic [7:0]        wdata;
    logic [7:0]        sel;
    logic [3:0]        cnt;
    logic              win;
    logic [8:0]        div_t;
    logic [8:0]        wc_inc;
    logic              copy_more;

    always_comb begin
        eff_n = i_cfg.slot_count;
        if (i_cfg.slot_count == 9'd0) begin
            eff_n = 9'd1;
        end else if (i_cfg.slot_count > 9'(MAX_SLOTS)) begin
            eff_n = 9'(MAX_SLOTS);
        end
        eff_c = i_cfg.copies_per_slot;
        if (i_cfg.copies_per_slot < 4'(MIN_COPIES)) begin
            eff_c = 4'(MIN_COPIES);
        end else if (i_cfg.copies_per_slot > 4'(MAX_COPIES)) begin
            eff_c = 4'(MAX_COPIES);
        end
    end

    assign total    = 13'(eff_n) * 13'(eff_c);
    assign prod     = 12'(r_slot) * 12'(eff_c);
    assign slot_sum = 12'(i_cfg.base_address) + prod + 12'(r_copy);

    // ring fill walks a linear offset, otherwise slot and copy pick the byte
    always_comb begin
        if (i_ctl.act == A_FILL && !i_ctl.wr_path) begin
            addr = i_cfg.base_address + r_lin[ADDR_W-1:0];
        end else begin
            addr = slot_sum[ADDR_W-1:0];
        end
    end

    always_comb begin
        mem_we = 1'b0;
        wdata  = i_cfg.empty_marker;
        if (i_ctl.act == A_FILL) begin
            mem_we = 1'b1;
        end else if (i_ctl.act == A_RD && i_ctl.wr_path) begin
            mem_we = 1'b1;
            wdata  = r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= wdata;
        end
        if (i_ctl.act == A_RD && !i_ctl.wr_path) begin
            r_rdata <= r_mem[addr];
        end
    end

    // majority vote of copy r_copy against itself and the later copies
    always_comb begin
        sel = r_buf[r_copy];
        cnt = '0;
        for (int j = 0; j < MAX_COPIES; j++) begin
            if ((4'(j) >= 4'(r_copy)) && (4'(j) < eff_c) && (r_buf[j] == sel)) begin
                cnt = cnt + 1'b1;
            end
        end
        win = (cnt >= ((eff_c >> 1) + 4'd1));
    end

    assign div_t     = {r_rem, r_dvd[8]};
    assign wc_inc    = r_wc + 9'd1;
    assign copy_more = (4'(r_copy) + 4'd1) < eff_c;

    always_comb begin
        n_cur = r_cur;
        n_wc  = r_wc;
        case (i_ctl.act)
            A_SET_CUR: n_cur = r_rem;
            A_SCAN_EVAL: begin
                if (r_vok && r_vval != i_cfg.empty_marker) begin
                    n_cur = r_slot;
                end
            end
            A_SCAN_INIT: begin
                if (i_ctl.wr_path) begin
                    n_wc = (wc_inc > eff_n) ? 9'd1 : wc_inc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_wc  <= '0;
        end else begin
            r_cur <= n_cur;
            r_wc  <= n_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_rv    <= '0;
            r_fault <= 1'b0;
            r_wv    <= i_item.write_value;
            r_start <= i_item.start_slot;
        end
        case (i_ctl.act)
            A_DIV_LD_START: begin
                r_dvd  <= {1'b0, r_start};
                r_rem  <= '0;
                r_dcnt <= 4'd8;
                r_lin  <= '0;
            end
            A_DIV_LD_NEXT: begin
                r_dvd  <= 9'(r_cur) + 9'd1;
                r_rem  <= '0;
                r_dcnt <= 4'd8;
            end
            A_DIV_STEP: begin
                if (div_t >= eff_n) begin
                    r_rem <= 8'(div_t - eff_n);
                end else begin
                    r_rem <= div_t[7:0];
                end
                r_dvd  <= {r_dvd[7:0], 1'b0};
                r_dcnt <= r_dcnt - 4'd1;
            end
            A_SET_CUR: begin
                r_slot <= r_rem;
                r_copy <= '0;
            end
            A_FILL: begin
                r_lin  <= r_lin + 11'd1;
                r_copy <= copy_more ? r_copy + 1'b1 : '0;
            end
            A_SEL_CUR: begin
                r_slot   <= r_cur;
                r_copy   <= '0;
                r_vok    <= 1'b0;
                r_resume <= 1'b0;
            end
            A_SCAN_INIT: begin
                if (i_ctl.wr_path) begin
                    r_adv <= (wc_inc > eff_n);
                    r_slot <= r_cur;
                end else begin
                    r_slot   <= '0;
                    r_found  <= 1'b0;
                    r_resume <= 1'b1;
                end
                r_copy <= '0;
                r_vok  <= 1'b0;
            end
            A_RD: begin
                if (i_ctl.wr_path) begin
                    r_copy <= copy_more ? r_copy + 1'b1 : '0;
                end
            end
            A_CAP: begin
                r_buf[r_copy] <= r_rdata;
                r_copy        <= copy_more ? r_copy + 1'b1 : '0;
            end
            A_VOTE: begin
                if (win) begin
                    r_vok  <= 1'b1;
                    r_vval <= sel;
                end
                r_copy <= r_copy + 1'b1;
            end
            A_READ_RES: begin
                r_rv    <= r_vok ? r_vval : i_cfg.error_marker;
                r_fault <= !r_vok;
            end
            A_SCAN_EVAL: begin
                if (r_vok && r_vval != i_cfg.empty_marker) begin
                    r_found <= 1'b1;
                end
                if (!r_vok) begin
                    r_fault <= 1'b1;
                end
            end
            A_SCAN_NEXT: begin
                r_slot <= r_slot + 1'b1;
                r_copy <= '0;
                r_vok  <= 1'b0;
            end
            A_SCAN_END: begin
                r_fault <= r_fault | !r_found;
            end
            A_FIN: begin
                r_res.read_value <= r_rv;
                r_res.fault      <= r_fault;
                r_res.slot_now   <= r_cur;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.div_more  = (r_dcnt != 4'd0);
    assign o_stat.lin_more  = (13'(r_lin) + 13'd1) < total;
    assign o_stat.copy_more = copy_more;
    assign o_stat.vote_more = !win && ((4'(r_copy) + 4'd2) < eff_c);
    assign o_stat.resume    = r_resume;
    assign o_stat.hit       = r_vok && (r_vval != i_cfg.empty_marker);
    assign o_stat.slot_more = (9'(r_slot) + 9'd1) < eff_n;
    assign o_stat.no_adv    = !r_adv;
    assign o_result         = r_res;

endmodule

[design/wlvb_checker.sv]
// wlvb_checker: port-level checks of the voted byte store handshake and sequencing
// bound to wear_levelled_voted_byte_store_core
module wlvb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result without an item in flight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("reset did not clear the sequencer");

endmodule

bind wear_levelled_voted_byte_store_core wlvb_checker u_wlvb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

[tb/tb_wear_levelled_voted_byte_store_core.sv]
// tb_wear_levelled_voted_byte_store_core: self-checking bench for the voted byte store core
// drives items and register writes, predicts each result from a shadow copy of the store
// depends on wlvb_pkg and wear_levelled_voted_byte_store_core
module tb_wear_levelled_voted_byte_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wlvb_pkg::*;

    localparam int QUIET_LIMIT   = 30000;
    localparam int ITEM_TARGET   = 1650;
    localparam int SETTLE_CYCLES = 64;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_item                 i_item     = '0;
    logic                  o_valid;
    t_result               o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [7:0] shadow_mem [STORE_BYTES];
    bit         shadow_known [STORE_BYTES];
    logic [7:0] shadow_slot  = '0;
    logic [8:0] shadow_count = '0;
    t_cfg       shadow_cfg   = '{9'd16, 10'd0, 4'd3, 8'd255, 8'd254};
    t_result    due_results [$];
    int         mismatches   = 0;
    int         items_sent   = 0;
    int         quiet_cycles = 0;
    bit         no_gaps      = 1'b0;

    wear_levelled_voted_byte_store_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int ring_slots();
        int n;
        n = shadow_cfg.slot_count;
        if (n == 0) n = 1;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        return n;
    endfunction

    function automatic int slot_copies();
        int c;
        c = shadow_cfg.copies_per_slot;
        if (c < MIN_COPIES) c = MIN_COPIES;
        if (c > MAX_COPIES) c = MAX_COPIES;
        return c;
    endfunction

    function automatic int copy_addr(int slot, int copy);
        return (int'(shadow_cfg.base_address) + slot * slot_copies() + copy) % STORE_BYTES;
    endfunction

    function automatic void fill_slot(int slot, logic [7:0] v);
        for (int i = 0; i < slot_copies(); i++) begin
            shadow_mem[copy_addr(slot, i)]   = v;
            shadow_known[copy_addr(slot, i)] = 1'b1;
        end
    endfunction

    function automatic bit slot_vote(int slot, output logic [7:0] v);
        int c;
        int hits;
        c = slot_copies();
        v = '0;
        for (int i = 0; i + 1 < c; i++) begin
            hits = 1;
            for (int j = i + 1; j < c; j++)
                if (shadow_mem[copy_addr(slot, j)] == shadow_mem[copy_addr(slot, i)]) hits++;
            if (hits >= c / 2 + 1) begin
                v = shadow_mem[copy_addr(slot, i)];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit slot_known(int slot);
        for (int i = 0; i < slot_copies(); i++)
            if (!shadow_known[copy_addr(slot, i)]) return 1'b0;
        return 1'b1;
    endfunction

    // reads and resume scans may only touch bytes written before
    function automatic bit reads_known(logic [1:0] func);
        logic [7:0] v;
        if (func == FUNC_READ) return slot_known(int'(shadow_slot));
        if (func != FUNC_RESUME) return 1'b1;
        for (int i = 0; i < ring_slots(); i++) begin
            if (!slot_known(i)) return 1'b0;
            if (slot_vote(i, v) && v != shadow_cfg.empty_marker) return 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_result run_store_op(t_item it);
        t_result    r;
        logic [7:0] v;
        int         n;
        bit         found;
        r = '0;
        n = ring_slots();
        case (it.func)
            FUNC_FRESH: begin
                shadow_slot = 8'(int'(it.start_slot) % n);
                for (int i = 0; i < n; i++) fill_slot(i, shadow_cfg.empty_marker);
            end
            FUNC_RESUME: begin
                found = 1'b0;
                for (int i = 0; i < n && !found; i++) begin
                    if (slot_vote(i, v)) begin
                        if (v != shadow_cfg.empty_marker) begin
                            shadow_slot = 8'(i);
                            found = 1'b1;
                        end
                    end else begin
                        r.fault = 1'b1;
                    end
                end
                if (!found) r.fault = 1'b1;
            end
            FUNC_READ: begin
                if (slot_vote(int'(shadow_slot), v)) begin
                    r.read_value = v;
                end else begin
                    r.read_value = shadow_cfg.error_marker;
                    r.fault = 1'b1;
                end
            end
            default: begin
                shadow_count = shadow_count + 9'd1;
                if (int'(shadow_count) > n) begin
                    shadow_count = 9'd1;
                    fill_slot(int'(shadow_slot), shadow_cfg.empty_marker);
                    shadow_slot = 8'((int'(shadow_slot) + 1) % n);
                end
                fill_slot(int'(shadow_slot), it.write_value);
            end
        endcase
        r.slot_now = shadow_slot;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(logic [1:0] func, logic [7:0] value, logic [7:0] slot);
        t_item it;
        int    gap;
        it.func        = func;
        it.write_value = value;
        it.start_slot  = slot;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        due_results.push_back(run_store_op(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (due_results.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pad_reg(int width, int value);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((1 << width) - 1);
        return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
    endfunction

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_SLOT_COUNT: shadow_cfg.slot_count      = data[8:0];
            REG_BASE_ADDR:  shadow_cfg.base_address    = data[9:0];
            REG_COPIES:     shadow_cfg.copies_per_slot = data[3:0];
            REG_EMPTY_MARK: shadow_cfg.empty_marker    = data[7:0];
            REG_ERROR_MARK: shadow_cfg.error_marker    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(t_cfg next, logic [4:0] pick);
        wait_idle();
        if (pick[REG_SLOT_COUNT]) put_reg(REG_SLOT_COUNT, pad_reg(9, next.slot_count));
        if (pick[REG_BASE_ADDR])  put_reg(REG_BASE_ADDR, pad_reg(10, next.base_address));
        if (pick[REG_COPIES])     put_reg(REG_COPIES, pad_reg(4, next.copies_per_slot));
        if (pick[REG_EMPTY_MARK]) put_reg(REG_EMPTY_MARK, pad_reg(8, next.empty_marker));
        if (pick[REG_ERROR_MARK]) put_reg(REG_ERROR_MARK, pad_reg(8, next.error_marker));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)      c.slot_count = 9'($urandom_range(1, 8));
        else if (roll < 82) c.slot_count = 9'($urandom_range(9, 40));
        else if (roll < 88) c.slot_count = '0;
        else if (roll < 94) c.slot_count = 9'($urandom_range(257, 511));
        else                c.slot_count = 9'($urandom_range(41, 256));
        roll = $urandom_range(0, 99);
        if (roll < 70)      c.copies_per_slot = 4'($urandom_range(2, 8));
        else if (roll < 85) c.copies_per_slot = 4'($urandom_range(0, 1));
        else                c.copies_per_slot = 4'($urandom_range(9, 15));
        if ($urandom_range(0, 3) == 0) c.base_address = 10'($urandom_range(1000, 1023));
        else                           c.base_address = 10'($urandom_range(0, 1023));
        c.empty_marker = 8'($urandom);
        if ($urandom_range(0, 4) == 0) c.error_marker = c.empty_marker;
        else                           c.error_marker = 8'($urandom);
        return c;
    endfunction

    task automatic test_basic_ops();
        send_item(FUNC_FRESH, 8'($urandom), 8'd255);
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
        send_item(FUNC_WRITE, 8'h00, 8'($urandom));
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
        send_item(FUNC_WRITE, 8'hff, 8'($urandom));
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
        // every slot now holds the empty marker, so the scan finds nothing
        send_item(FUNC_RESUME, 8'($urandom), 8'($urandom));
        send_item(FUNC_WRITE, 8'ha5, 8'($urandom));
        send_item(FUNC_RESUME, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_vote_failure();
        t_cfg next;
        send_item(FUNC_FRESH, 8'($urandom), 8'd1);
        send_item(FUNC_WRITE, 8'h3c, 8'($urandom));
        // cutting the copies from three to two splits the written slot across two slots
        next = shadow_cfg;
        next.copies_per_slot = 4'd2;
        apply_config(next, 5'(1 << REG_COPIES));
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
        send_item(FUNC_RESUME, 8'($urandom), 8'($urandom));
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_small_ring();
        t_cfg next;
        next = '{9'd1, 10'd0, 4'd3, 8'd255, 8'd0};
        apply_config(next, 5'b11111);
        send_item(FUNC_FRESH, 8'($urandom), 8'd200);
        repeat (4) send_item(FUNC_WRITE, 8'($urandom), 8'($urandom));
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
        send_item(FUNC_RESUME, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_wrapped_extremes();
        t_cfg next;
        next = '{9'd256, 10'd1023, 4'd8, 8'd0, 8'd255};
        apply_config(next, 5'b11111);
        send_item(FUNC_FRESH, 8'($urandom), 8'd255);
        send_item(FUNC_WRITE, 8'h80, 8'($urandom));
        send_item(FUNC_READ, 8'($urandom), 8'($urandom));
        send_item(FUNC_RESUME, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_random_phases();
        t_cfg       next;
        logic [4:0] pick;
        int         ops;
        int         roll;
        logic [1:0] func;
        logic [7:0] value;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            next = random_cfg();
            if (roll < 70) pick = 5'b11111;
            else           pick = 5'($urandom_range(1, 31));
            apply_config(next, pick);
            no_gaps = ($urandom_range(0, 4) == 0);
            // skipping init after a layout change leaves mixed copies behind
            if (roll < 65) send_item(FUNC_FRESH, 8'($urandom), 8'($urandom));
            ops = (ring_slots() > 32) ? $urandom_range(4, 10) : $urandom_range(20, 60);
            repeat (ops) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)      func = FUNC_WRITE;
                else if (roll < 75) func = FUNC_READ;
                else if (roll < 90) func = FUNC_RESUME;
                else                func = FUNC_FRESH;
                if (func == FUNC_RESUME && ring_slots() > 32 && $urandom_range(0, 2) != 0)
                    func = FUNC_READ;
                if (!reads_known(func)) func = FUNC_WRITE;
                roll = $urandom_range(0, 99);
                if (roll < 15)      value = shadow_cfg.empty_marker;
                else if (roll < 20) value = shadow_cfg.error_marker;
                else                value = 8'($urandom);
                send_item(func, value, 8'($urandom));
            end
        end
        no_gaps = 1'b0;
    endtask

    function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s at %0t ns: expected %0h, got %0h", what, $time, want, got);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (due_results.size() == 0) begin
                note_mismatch("result with nothing pending, slot_now", '0, o_result.slot_now);
            end else begin
                want = due_results.pop_front();
                if (o_result.read_value !== want.read_value)
                    note_mismatch("read_value", want.read_value, o_result.read_value);
                if (o_result.fault !== want.fault)
                    note_mismatch("fault", 8'(want.fault), 8'(o_result.fault));
                if (o_result.slot_now !== want.slot_now)
                    note_mismatch("slot_now", want.slot_now, o_result.slot_now);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_vote_failure();
        test_small_ring();
        test_wrapped_extremes();
        test_random_phases();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
design/wlvb_pkg.sv
design/wlvb_seq.sv
design/wlvb_dpath.sv
design/wear_levelled_voted_byte_store_core.sv
design/wlvb_checker.sv
tb/tb_wear_levelled_voted_byte_store_core.sv
